// ----- design/circle_rasterizer_defines.svh -----
// ----------------------------------------------------------------------------
// Circle rasterizer assertion macros
// Shared concurrent-assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_RASTERIZER_DEFINES_SVH
`define CIRCLE_RASTERIZER_DEFINES_SVH

// same-cycle implication
`define CRAST_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("circle_rasterizer: same-cycle check failed");

// next-cycle implication
`define CRAST_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("circle_rasterizer: next-cycle check failed");

`endif

// ----- design/crast_pkg.sv -----
// ----------------------------------------------------------------------------
// Circle rasterizer package
// Opcodes, decision constants and the step record passed front to back.
// ----------------------------------------------------------------------------
package crast_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [2:0] OCT_LAST = 3'd7;

    localparam logic [12:0] DEC_INIT     = 13'd3;
    localparam logic [12:0] DEC_INC_HOLD = 13'd6;
    localparam logic [12:0] DEC_INC_DIAG = 13'd10;

    typedef struct packed {
        logic signed [10:0] cx;
        logic signed [10:0] cy;
        logic        [8:0]  x;
        logic        [8:0]  y;
        logic               last;
    } job_t;

endpackage

// ----- design/crast_front.sv -----
// ----------------------------------------------------------------------------
// Circle rasterizer front end
// Accepts requests, keeps the Bresenham state and queues one step record
// per step request issued while a circle is being drawn.
// ----------------------------------------------------------------------------
module crast_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_opcode,
    input  logic signed [10:0]     s_center_x,
    input  logic signed [10:0]     s_center_y,
    input  logic        [8:0]      s_radius,
    input  logic                   q_full,
    output logic                   q_push,
    output crast_pkg::job_t        q_data
);

    logic        [8:0]  step_x_reg, step_x_next;
    logic        [8:0]  step_y_reg, step_y_next;
    logic        [12:0] dec_reg, dec_next;
    logic signed [10:0] cx_reg, cx_next;
    logic signed [10:0] cy_reg, cy_next;
    logic               drawing_reg, drawing_next;

    logic               accept;
    logic               take_y;
    logic        [12:0] dec_step;
    logic signed [10:0] nx;
    logic signed [10:0] ny;
    logic               done;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        take_y   = !dec_reg[12];
        if (take_y) begin
            dec_step = dec_reg + {2'b00, step_x_reg, 2'b00} - {2'b00, step_y_reg, 2'b00}
                       + crast_pkg::DEC_INC_DIAG;
        end else begin
            dec_step = dec_reg + {2'b00, step_x_reg, 2'b00} + crast_pkg::DEC_INC_HOLD;
        end
        nx   = $signed({2'b00, step_x_reg}) + 11'sd1;
        ny   = $signed({2'b00, step_y_reg}) - (take_y ? 11'sd1 : 11'sd0);
        done = nx > ny;
    end

    always_comb begin
        step_x_next  = step_x_reg;
        step_y_next  = step_y_reg;
        dec_next     = dec_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        drawing_next = drawing_reg;
        q_push       = 1'b0;
        if (accept) begin
            if (s_opcode == crast_pkg::OP_START) begin
                step_x_next  = '0;
                step_y_next  = s_radius;
                dec_next     = crast_pkg::DEC_INIT - {3'b000, s_radius, 1'b0};
                cx_next      = s_center_x;
                cy_next      = s_center_y;
                drawing_next = 1'b1;
            end else if (drawing_reg) begin
                q_push       = 1'b1;
                step_x_next  = nx[8:0];
                step_y_next  = ny[8:0];
                dec_next     = dec_step;
                drawing_next = !done;
            end
        end
    end

    always_comb begin
        q_data.cx   = cx_reg;
        q_data.cy   = cy_reg;
        q_data.x    = step_x_reg;
        q_data.y    = step_y_reg;
        q_data.last = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_x_reg  <= '0;
            step_y_reg  <= '0;
            dec_reg     <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            drawing_reg <= 1'b0;
        end else begin
            step_x_reg  <= step_x_next;
            step_y_reg  <= step_y_next;
            dec_reg     <= dec_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            drawing_reg <= drawing_next;
        end
    end

endmodule

// ----- design/crast_queue.sv -----
// ----------------------------------------------------------------------------
// Circle rasterizer step queue
// Small register FIFO of step records between front and back end.
// DEPTH must be 2 or more.
// ----------------------------------------------------------------------------
module crast_queue #(
    parameter int DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  crast_pkg::job_t push_data,
    output logic            full,
    input  logic            pop,
    output crast_pkg::job_t pop_data,
    output logic            empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    crast_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/crast_back.sv -----
// ----------------------------------------------------------------------------
// Circle rasterizer back end
// Expands one step record into its eight mirrored points, one per cycle
// while m_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module crast_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  crast_pkg::job_t    q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [11:0] m_point_x,
    output logic signed [11:0] m_point_y,
    output logic        [2:0]  m_octant,
    output logic               m_last_of_circle
);

    crast_pkg::job_t    job_reg, job_next;
    logic               busy_reg, busy_next;
    logic [2:0]         oct_reg, oct_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [11:0] px_reg, px_next;
    logic signed [11:0] py_reg, py_next;
    logic [2:0]         m_oct_reg, m_oct_next;
    logic               m_last_reg, m_last_next;

    logic               advance;
    logic               load;
    logic               at_last;
    logic signed [11:0] cx12;
    logic signed [11:0] cy12;
    logic signed [11:0] a12;
    logic signed [11:0] b12;

    assign at_last = (oct_reg == crast_pkg::OCT_LAST);
    assign advance = busy_reg && (!m_valid_reg || m_ready);
    assign load    = !q_empty && (!busy_reg || (advance && at_last));
    assign q_pop   = load;

    always_comb begin
        cx12 = {job_reg.cx[10], job_reg.cx};
        cy12 = {job_reg.cy[10], job_reg.cy};
        a12  = $signed({3'b000, (oct_reg[2] ? job_reg.y : job_reg.x)});
        b12  = $signed({3'b000, (oct_reg[2] ? job_reg.x : job_reg.y)});
    end

    always_comb begin
        job_next     = load ? q_data : job_reg;
        oct_next     = advance ? oct_reg + 3'd1 : oct_reg;
        busy_next    = busy_reg;
        if (load) begin
            busy_next = 1'b1;
        end else if (advance && at_last) begin
            busy_next = 1'b0;
        end
        m_valid_next = m_valid_reg && !m_ready;
        px_next      = px_reg;
        py_next      = py_reg;
        m_oct_next   = m_oct_reg;
        m_last_next  = m_last_reg;
        if (advance) begin
            m_valid_next = 1'b1;
            px_next      = oct_reg[1] ? cx12 - a12 : cx12 + a12;
            py_next      = oct_reg[0] ? cy12 - b12 : cy12 + b12;
            m_oct_next   = oct_reg;
            m_last_next  = job_reg.last && at_last;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        m_oct_reg  <= m_oct_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            oct_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            oct_reg     <= oct_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_point_x        = px_reg;
    assign m_point_y        = py_reg;
    assign m_octant         = m_oct_reg;
    assign m_last_of_circle = m_last_reg;

endmodule

// ----- design/circle_rasterizer.sv -----
// ----------------------------------------------------------------------------
// Circle rasterizer
// Bresenham midpoint circle generator with eight-way symmetry.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: requests. opcode START loads center and radius and emits
//   nothing; opcode STEP emits the eight mirrored points of the current
//   octant step, then advances the decision value. A STEP while idle is
//   absorbed with no output.
//   m_* channel: eight points per STEP request, octants 0..7 in order;
//   m_last_of_circle marks octant 7 of the final step.
//   Throughput: the output stage emits one point per cycle while m_ready is
//   high. The front end keeps accepting until QUEUE_DEPTH steps are pending.
//   Path: with the back end idle, a step record goes from the queue into its
//   job register, and its first point is then registered in the output stage.
//   Reset: aresetn (synchronous, active low) empties the queue, drops any
//   pending points and returns to idle.
//   Stall: m_ready low holds the current point; the queue then fills and
//   s_ready drops.
// ----------------------------------------------------------------------------
module circle_rasterizer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic signed [10:0] s_center_x,
    input  logic signed [10:0] s_center_y,
    input  logic        [8:0]  s_radius,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [11:0] m_point_x,
    output logic signed [11:0] m_point_y,
    output logic        [2:0]  m_octant,
    output logic               m_last_of_circle
);

    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    crast_pkg::job_t q_wdata;
    crast_pkg::job_t q_rdata;

    crast_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_radius   (s_radius),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    crast_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    crast_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (q_empty),
        .q_data           (q_rdata),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_point_x        (m_point_x),
        .m_point_y        (m_point_y),
        .m_octant         (m_octant),
        .m_last_of_circle (m_last_of_circle)
    );

endmodule

// ----- design/crast_checker.sv -----
// ----------------------------------------------------------------------------
// Circle rasterizer port checker
// Watches the result channel for hold, octant order and end marking.
// ----------------------------------------------------------------------------
`include "circle_rasterizer_defines.svh"

module crast_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [11:0] m_point_x,
    input logic signed [11:0] m_point_y,
    input logic        [2:0]  m_octant,
    input logic               m_last_of_circle
);

    `CRAST_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_point_x) && $stable(m_point_y) && $stable(m_octant) && $stable(m_last_of_circle))

    `CRAST_ASSERT_NOW(a_last_on_final_octant, aclk, aresetn, m_valid && m_last_of_circle, m_octant == crast_pkg::OCT_LAST)

    `CRAST_ASSERT_NEXT(a_octant_sequence, aclk, aresetn, m_valid && m_ready && (m_octant != crast_pkg::OCT_LAST), m_valid && (m_octant == $past(m_octant) + 3'd1))

endmodule

bind circle_rasterizer crast_checker u_crast_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_point_x        (m_point_x),
    .m_point_y        (m_point_y),
    .m_octant         (m_octant),
    .m_last_of_circle (m_last_of_circle)
);

// ----- tb/circle_rasterizer_tb.sv -----
// ----------------------------------------------------------------------------
// Circle rasterizer testbench
// Drives start and step requests into circle_rasterizer and tracks the
// midpoint circle walk in a local model. Every emitted point is compared
// field by field against the model's queue of pending points. Covers idle
// steps, zero and maximum radius, extreme centers, abandoned circles, random
// circles with random gaps on both channels, and one long output stall.
// ----------------------------------------------------------------------------
module circle_rasterizer_tb;

    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int RANDOM_REQUESTS = 170;

    typedef struct packed {
        logic signed [11:0] px;
        logic signed [11:0] py;
        logic        [2:0]  oct;
        logic               last;
    } point_t;

    logic               aclk;
    logic               aresetn    = 1'b0;
    logic               s_valid    = 1'b0;
    logic               s_ready;
    logic               s_opcode   = crast_pkg::OP_STEP;
    logic signed [10:0] s_center_x = '0;
    logic signed [10:0] s_center_y = '0;
    logic        [8:0]  s_radius   = '0;
    logic               m_valid;
    logic               m_ready    = 1'b0;
    logic signed [11:0] m_point_x;
    logic signed [11:0] m_point_y;
    logic        [2:0]  m_octant;
    logic               m_last_of_circle;

    // circle walk state
    logic        [8:0]  walk_x;
    logic        [8:0]  walk_y;
    logic signed [12:0] walk_dec;
    logic signed [10:0] walk_cx;
    logic signed [10:0] walk_cy;
    bit                 drawing;

    point_t expected_points[$];

    int  errors         = 0;
    int  requests_done  = 0;
    int  points_checked = 0;
    int  circles_done   = 0;
    int  idle_cycles    = 0;
    bit  calm           = 1'b0;
    bit  hold_req       = 1'b0;

    circle_rasterizer uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_center_x       (s_center_x),
        .s_center_y       (s_center_y),
        .s_radius         (s_radius),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_point_x        (m_point_x),
        .m_point_y        (m_point_y),
        .m_octant         (m_octant),
        .m_last_of_circle (m_last_of_circle)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // returns 1 when the request does something (idle steps are ignored)
    function automatic bit advance_circle(input logic op, input logic signed [10:0] cx,
                                          input logic signed [10:0] cy, input logic [8:0] r);
        int     x;
        int     y;
        int     p;
        int     nx;
        int     ny;
        int     ox;
        int     oy;
        int     px[8];
        int     py[8];
        bit     fin;
        point_t pt;
        if (op == crast_pkg::OP_START) begin
            walk_cx  = cx;
            walk_cy  = cy;
            walk_x   = '0;
            walk_y   = r;
            walk_dec = crast_pkg::DEC_INIT - {r, 1'b0};
            drawing  = 1'b1;
            return 1'b1;
        end
        if (!drawing)
            return 1'b0;
        x  = int'(walk_x);
        y  = int'(walk_y);
        p  = int'(walk_dec);
        ox = int'(walk_cx);
        oy = int'(walk_cy);
        px[0] = ox + x; py[0] = oy + y;
        px[1] = ox + x; py[1] = oy - y;
        px[2] = ox - x; py[2] = oy + y;
        px[3] = ox - x; py[3] = oy - y;
        px[4] = ox + y; py[4] = oy + x;
        px[5] = ox + y; py[5] = oy - x;
        px[6] = ox - y; py[6] = oy + x;
        px[7] = ox - y; py[7] = oy - x;
        if (p < 0) begin
            p  = p + 4 * x + int'(crast_pkg::DEC_INC_HOLD);
            ny = y;
        end else begin
            p  = p + 4 * (x - y) + int'(crast_pkg::DEC_INC_DIAG);
            ny = y - 1;
        end
        nx  = x + 1;
        fin = nx > ny;
        for (int k = 0; k < 8; k++) begin
            pt.px   = 12'(px[k]);
            pt.py   = 12'(py[k]);
            pt.oct  = 3'(k);
            pt.last = fin && (3'(k) == crast_pkg::OCT_LAST);
            expected_points.push_back(pt);
        end
        walk_x   = 9'(nx);
        walk_y   = 9'(ny);
        walk_dec = 13'(p);
        if (fin)
            drawing = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_request(input logic op, input logic signed [10:0] cx,
                                input logic signed [10:0] cy, input logic [8:0] r);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_center_x <= cx;
        s_center_y <= cy;
        s_radius   <= r;
        do
            @(posedge aclk);
        while (!s_ready);
        if (advance_circle(op, cx, cy, r))
            requests_done++;
    endtask

    // step payload fields are don't-care, so randomize them
    task automatic send_step();
        send_request(crast_pkg::OP_STEP, 11'($urandom), 11'($urandom), 9'($urandom));
    endtask

    task automatic run_circle(input logic signed [10:0] cx, input logic signed [10:0] cy,
                              input logic [8:0] r, input int max_steps);
        int n;
        send_request(crast_pkg::OP_START, cx, cy, r);
        n = 0;
        while (drawing && n < max_steps) begin
            send_step();
            n++;
        end
    endtask

    task automatic test_idle_step();
        send_step();
        send_step();
    endtask

    task automatic test_zero_radius();
        run_circle(11'sd0, 11'sd0, 9'd0, 1000);
        send_step();
    endtask

    task automatic test_extreme_centers();
        run_circle(11'sd1023, -11'sd1024, 9'd511, 3);
        run_circle(-11'sd1024, 11'sd1023, 9'd511, 3);
        run_circle(11'sd1023, 11'sd1023, 9'd1, 1000);
        run_circle(-11'sd1024, -11'sd1024, 9'd2, 1000);
    endtask

    task automatic test_output_stall();
        hold_req = 1'b1;
        run_circle(11'($urandom), 11'($urandom), 9'd60, 12);
        while (hold_req)
            @(posedge aclk);
    endtask

    task automatic test_random_circles();
        int         pick;
        logic [8:0] r;
        while (requests_done < RANDOM_REQUESTS) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                r = 9'($urandom_range(0, 12));
                run_circle(11'($urandom), 11'($urandom), r, 1000);
            end else if (pick < 6) begin
                r = 9'($urandom_range(13, 40));
                run_circle(11'($urandom), 11'($urandom), r, 1000);
            end else if (pick == 6) begin
                r = 9'($urandom);
                run_circle(11'($urandom), 11'($urandom), r, $urandom_range(1, 8));
            end else if (pick == 7) begin
                r = 9'($urandom_range(3, 30));
                run_circle(11'($urandom), 11'($urandom), r, $urandom_range(0, 3));
            end else begin
                repeat ($urandom_range(1, 2)) send_step();
            end
        end
    endtask

    task automatic test_steady_tail();
        calm = 1'b1;
        repeat (2) run_circle(11'($urandom), 11'($urandom), 9'($urandom_range(5, 20)), 1000);
    endtask

    // output side: random stalls, plus one long hold on request
    initial begin : point_sink
        int stall_count;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                for (stall_count = 0; stall_count < HOLD_CYCLES; stall_count++)
                    @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : point_check
        point_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                $error("unexpected point (%0d,%0d) octant %0d", m_point_x, m_point_y, m_octant);
                errors++;
            end else begin
                want = expected_points.pop_front();
                if (m_point_x !== want.px) begin
                    $error("point_x: expected %0d, got %0d", want.px, m_point_x);
                    errors++;
                end
                if (m_point_y !== want.py) begin
                    $error("point_y: expected %0d, got %0d", want.py, m_point_y);
                    errors++;
                end
                if (m_octant !== want.oct) begin
                    $error("octant: expected %0d, got %0d", want.oct, m_octant);
                    errors++;
                end
                if (m_last_of_circle !== want.last) begin
                    $error("last_of_circle: expected %0d, got %0d", want.last,
                           m_last_of_circle);
                    errors++;
                end
                points_checked++;
                if (want.last)
                    circles_done++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or point moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_step();
        test_zero_radius();
        test_extreme_centers();
        test_output_stall();
        test_random_circles();
        test_steady_tail();
        s_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Ran %0d requests: %0d points checked, %0d circles completed,", requests_done,
                 points_checked, circles_done);
        $display("with idle steps, extreme centers and radii, aborts and a long output stall.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
